// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the anomaly solver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define KAS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that also holds during reset
`define KAS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- rtl/kas_pkg.sv -----
// ----------------------------------------------------------------------------
// kas_pkg
// Types and constants shared by the anomaly solver controller and datapath.
// ----------------------------------------------------------------------------
package kas_pkg;

    // fixed formats
    localparam int ANGLE_BITS   = 32;
    localparam int CORDIC_STEPS = 32;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 66;
    localparam int VW           = 36;   // cordic vector width, signed Q30
    localparam int ZW           = 34;   // residual / angle accumulator width
    localparam int DW           = 34;   // newton denominator width
    localparam int CNT_W        = 7;

    localparam logic [30:0] INV_TWO_PI_Q32 = 31'd683565276;
    localparam logic signed [VW-1:0] INV_GAIN_Q30 = 36'sd652032874;

    // register indexes
    localparam logic [1:0] REG_MAX_ITER  = 2'd0;
    localparam logic [1:0] REG_TOLERANCE = 2'd1;

    // datapath operations
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_ROT_INIT,
        OP_ROT_STEP,
        OP_ROT_FIN,
        OP_EVAL_MUL,
        OP_EVAL_RES,
        OP_CHECK,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_UPDATE,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_FIN_MUL,
        OP_VEC_INIT,
        OP_VEC_STEP,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic cordic_last;
        logic div_last;
        logic sqrt_last;
        logic within_tol;
        logic at_limit;
    } dp_status_t;

    // arctangent of 2^-i in 2^-32 turns
    function automatic logic signed [ZW-1:0] arc_angle(input logic [CNT_W-1:0] i);
        logic signed [ZW-1:0] a;
        case (i)
            7'd0:    a = 34'h020000000;
            7'd1:    a = 34'h012E4051D;
            7'd2:    a = 34'h009FB385B;
            7'd3:    a = 34'h0051111D4;
            7'd4:    a = 34'h0028B0D43;
            7'd5:    a = 34'h00145D7E1;
            7'd6:    a = 34'h000A2F61E;
            7'd7:    a = 34'h000517C55;
            7'd8:    a = 34'h00028BE53;
            7'd9:    a = 34'h000145F2F;
            7'd10:   a = 34'h0000A2F98;
            7'd11:   a = 34'h0000517CC;
            7'd12:   a = 34'h000028BE6;
            7'd13:   a = 34'h0000145F3;
            7'd14:   a = 34'h00000A2FA;
            7'd15:   a = 34'h00000517D;
            7'd16:   a = 34'h0000028BE;
            7'd17:   a = 34'h00000145F;
            7'd18:   a = 34'h000000A30;
            7'd19:   a = 34'h000000518;
            7'd20:   a = 34'h00000028C;
            7'd21:   a = 34'h000000146;
            7'd22:   a = 34'h0000000A3;
            7'd23:   a = 34'h000000051;
            7'd24:   a = 34'h000000029;
            7'd25:   a = 34'h000000014;
            7'd26:   a = 34'h00000000A;
            7'd27:   a = 34'h000000005;
            7'd28:   a = 34'h000000003;
            7'd29:   a = 34'h000000001;
            7'd30:   a = 34'h000000001;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/kas_ctrl.sv -----
// ----------------------------------------------------------------------------
// kas_ctrl
// Sequencer for the solver: newton loop, final sqrt and atan2, output slot.
// ----------------------------------------------------------------------------
module kas_ctrl
    import kas_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    `include "assert_macros.svh"

    typedef enum logic [15:0] {
        S_IDLE      = 16'h0001,
        S_ROT_INIT  = 16'h0002,
        S_ROT       = 16'h0004,
        S_ROT_FIN   = 16'h0008,
        S_EVAL_MUL  = 16'h0010,
        S_EVAL_RES  = 16'h0020,
        S_CHECK     = 16'h0040,
        S_DIV_INIT  = 16'h0080,
        S_DIV       = 16'h0100,
        S_UPDATE    = 16'h0200,
        S_SQRT_INIT = 16'h0400,
        S_SQRT      = 16'h0800,
        S_FIN_MUL   = 16'h1000,
        S_VEC_INIT  = 16'h2000,
        S_VEC       = 16'h4000,
        S_OUT       = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_ROT_INIT;
                end
            end
            S_ROT_INIT:
            begin
                cmd.op     = OP_ROT_INIT;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                cmd.op = OP_ROT_STEP;
                if (status.cordic_last)
                begin
                    state_next = S_ROT_FIN;
                end
            end
            S_ROT_FIN:
            begin
                cmd.op     = OP_ROT_FIN;
                state_next = S_EVAL_MUL;
            end
            S_EVAL_MUL:
            begin
                cmd.op     = OP_EVAL_MUL;
                state_next = S_EVAL_RES;
            end
            S_EVAL_RES:
            begin
                cmd.op     = OP_EVAL_RES;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.op = OP_CHECK;
                if (status.within_tol || status.at_limit)
                begin
                    state_next = S_SQRT_INIT;
                end
                else
                begin
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.op     = OP_UPDATE;
                state_next = S_ROT_INIT;
            end
            S_SQRT_INIT:
            begin
                cmd.op     = OP_SQRT_INIT;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT_STEP;
                if (status.sqrt_last)
                begin
                    state_next = S_FIN_MUL;
                end
            end
            S_FIN_MUL:
            begin
                cmd.op     = OP_FIN_MUL;
                state_next = S_VEC_INIT;
            end
            S_VEC_INIT:
            begin
                cmd.op     = OP_VEC_INIT;
                state_next = S_VEC;
            end
            S_VEC:
            begin
                cmd.op = OP_VEC_STEP;
                if (status.cordic_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output slot valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.op == OP_OUT)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // a finished item waits while the output slot is stalled
    `KAS_ASSERT(a_out_wait, (state_reg == S_OUT && out_valid_reg && !out_ready) |=> (state_reg == S_OUT), "result lost while output stalled")
    // loading the slot always presents an item
    `KAS_ASSERT(a_out_load, (cmd.op == OP_OUT) |=> out_valid_reg, "loaded result not presented")
    // an accepted item starts the first rotation
    `KAS_ASSERT(a_take_start, (in_valid && in_ready) |=> (state_reg == S_ROT_INIT), "accepted item not started")
    // no result shown during reset
    `KAS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid_reg, "output valid during reset")

endmodule

// ----- rtl/kas_dp.sv -----
// ----------------------------------------------------------------------------
// kas_dp
// Solver datapath: shared cordic, serial divider, serial square root.
// ----------------------------------------------------------------------------
module kas_dp
    import kas_pkg::*;
(
    input  logic                         clk,
    input  dp_cmd_t                      cmd,
    output dp_status_t                   status,
    input  logic [31:0]                  mean_angle,
    input  logic [31:0]                  eccentricity,
    input  logic [5:0]                   max_iterations,
    input  logic [15:0]                  tolerance,
    output logic [31:0]                  eccentric_anomaly,
    output logic signed [31:0]           true_angle,
    output logic                         converged,
    output logic [5:0]                   steps_used
);

    logic [31:0]            ma_reg, e_reg, ea_reg;
    logic signed [VW-1:0]   x_reg, y_reg, c_reg, s_reg, t_reg, ec_reg;
    logic signed [ZW-1:0]   z_reg, res_reg;
    logic                   flip_reg, conv_reg, vzero_reg, ovf_reg;
    logic [5:0]             steps_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [DW-1:0]          den_reg, rem_reg;
    logic [65:0]            dvd_reg;
    logic [30:0]            q_reg;
    logic [63:0]            n_reg;
    logic [31:0]            root_reg;
    logic [33:0]            srem_reg;
    logic [31:0]            ea_out_reg, nu_out_reg;
    logic                   conv_out_reg;
    logic [5:0]             steps_out_reg;

    logic [4:0]             shr;
    logic signed [VW-1:0]   dx, dy;
    logic signed [ZW-1:0]   arc;
    logic signed [ZW-1:0]   z0;
    logic signed [68:0]     prod_es, prod_ec;
    logic signed [67:0]     prod_t, prod_t_sh;
    logic signed [68:0]     prod_es_sh, prod_ec_sh;
    logic [31:0]            ea_diff;
    logic [ZW-1:0]          res_calc;
    logic signed [36:0]     den_full;
    logic [ZW-1:0]          mag;
    logic [34:0]            rem_sh;
    logic                   ge;
    logic [34:0]            rem_sub;
    logic [30:0]            step_q;
    logic [35:0]            srem_sh, trial;
    logic                   sge;
    logic [35:0]            srem_sub;
    logic [32:0]            root_full;
    logic signed [69:0]     prod_y, prod_y_sh;
    logic [63:0]            e_sq;
    logic signed [VW-1:0]   x_fin;

    // cordic micro-rotation terms
    always_comb
    begin
        shr = cnt_reg[4:0];
        dx  = y_reg >>> shr;
        dy  = x_reg >>> shr;
        arc = arc_angle(cnt_reg);
        z0  = {{(ZW-32){ea_reg[31]}}, ea_reg};
    end

    // residual and denominator arithmetic
    always_comb
    begin
        prod_es    = $signed({1'b0, e_reg}) * s_reg;
        prod_ec    = $signed({1'b0, e_reg}) * c_reg;
        prod_es_sh = prod_es >>> 30;
        prod_ec_sh = prod_ec >>> 30;
        prod_t     = t_reg * $signed({1'b0, INV_TWO_PI_Q32});
        prod_t_sh  = prod_t >>> 32;
        ea_diff    = ea_reg - ma_reg;
        res_calc   = {{(ZW-32){ea_diff[31]}}, ea_diff} - prod_t_sh[ZW-1:0];
        den_full   = 37'sh1_0000_0000 - {ec_reg[VW-1], ec_reg};
        mag        = res_reg[ZW-1] ? (ZW'(0) - res_reg) : res_reg;
    end

    // restoring division step
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[65]};
        ge      = (rem_sh >= {1'b0, den_reg});
        rem_sub = rem_sh - {1'b0, den_reg};
        step_q  = ovf_reg ? 31'h7FFF_FFFF : q_reg;
    end

    // square root step and final products
    always_comb
    begin
        srem_sh   = {srem_reg, n_reg[63:62]};
        trial     = {2'b00, root_reg, 2'b01};
        sge       = (srem_sh >= trial);
        srem_sub  = srem_sh - trial;
        root_full = (e_reg == 32'd0) ? 33'h1_0000_0000 : {1'b0, root_reg};
        prod_y    = $signed({1'b0, root_full}) * s_reg;
        prod_y_sh = prod_y >>> 32;
        e_sq      = e_reg * e_reg;
        x_fin     = c_reg - $signed({6'b0, e_reg[31:2]});
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                ma_reg    <= mean_angle;
                e_reg     <= eccentricity;
                ea_reg    <= mean_angle;
                steps_reg <= '0;
            end
            OP_ROT_INIT:
            begin
                x_reg   <= INV_GAIN_Q30;
                y_reg   <= '0;
                cnt_reg <= '0;
                if (z0 > 34'sh0_4000_0000)
                begin
                    z_reg    <= z0 - 34'sh0_8000_0000;
                    flip_reg <= 1'b1;
                end
                else if (z0 < -34'sh0_4000_0000)
                begin
                    z_reg    <= z0 + 34'sh0_8000_0000;
                    flip_reg <= 1'b1;
                end
                else
                begin
                    z_reg    <= z0;
                    flip_reg <= 1'b0;
                end
            end
            OP_ROT_STEP:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (!z_reg[ZW-1])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - arc;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + arc;
                end
            end
            OP_ROT_FIN:
            begin
                c_reg <= flip_reg ? -x_reg : x_reg;
                s_reg <= flip_reg ? -y_reg : y_reg;
            end
            OP_EVAL_MUL:
            begin
                t_reg  <= prod_es_sh[VW-1:0];
                ec_reg <= prod_ec_sh[VW-1:0];
            end
            OP_EVAL_RES:
            begin
                res_reg <= $signed(res_calc);
                den_reg <= (den_full < 37'sd1) ? DW'(1) : den_full[DW-1:0];
            end
            OP_CHECK:
            begin
                conv_reg <= status.within_tol;
            end
            OP_DIV_INIT:
            begin
                dvd_reg <= {mag, 32'd0};
                rem_reg <= '0;
                q_reg   <= '0;
                ovf_reg <= 1'b0;
                cnt_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                dvd_reg <= {dvd_reg[64:0], 1'b0};
                rem_reg <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                q_reg   <= {q_reg[29:0], ge};
                ovf_reg <= ovf_reg | q_reg[30];
            end
            OP_UPDATE:
            begin
                steps_reg <= steps_reg + 1'b1;
                if (!res_reg[ZW-1] && (res_reg != '0))
                begin
                    ea_reg <= ea_reg - {1'b0, step_q};
                end
                else
                begin
                    ea_reg <= ea_reg + {1'b0, step_q};
                end
            end
            OP_SQRT_INIT:
            begin
                n_reg    <= 64'd0 - e_sq;
                root_reg <= '0;
                srem_reg <= '0;
                cnt_reg  <= '0;
            end
            OP_SQRT_STEP:
            begin
                cnt_reg  <= cnt_reg + 1'b1;
                n_reg    <= {n_reg[61:0], 2'b00};
                srem_reg <= sge ? srem_sub[33:0] : srem_sh[33:0];
                root_reg <= {root_reg[30:0], sge};
            end
            OP_FIN_MUL:
            begin
                x_reg <= x_fin;
                y_reg <= prod_y_sh[VW-1:0];
            end
            OP_VEC_INIT:
            begin
                cnt_reg   <= '0;
                vzero_reg <= (x_reg == '0) && (y_reg == '0);
                if (x_reg[VW-1])
                begin
                    x_reg <= -x_reg;
                    y_reg <= -y_reg;
                    z_reg <= 34'sh0_8000_0000;
                end
                else
                begin
                    z_reg <= '0;
                end
            end
            OP_VEC_STEP:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (!y_reg[VW-1])
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + arc;
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - arc;
                end
            end
            OP_OUT:
            begin
                ea_out_reg    <= ea_reg;
                nu_out_reg    <= vzero_reg ? 32'd0 : z_reg[31:0];
                conv_out_reg  <= conv_reg;
                steps_out_reg <= steps_reg;
            end
            default:
            begin
            end
        endcase
    end

    // status back to the sequencer
    always_comb
    begin
        status.cordic_last = (cnt_reg == CNT_W'(CORDIC_STEPS - 1));
        status.div_last    = (cnt_reg == CNT_W'(DIV_STEPS - 1));
        status.sqrt_last   = (cnt_reg == CNT_W'(SQRT_STEPS - 1));
        status.within_tol  = (mag <= {{(ZW-16){1'b0}}, tolerance});
        status.at_limit    = (steps_reg >= max_iterations);
    end

    assign eccentric_anomaly = ea_out_reg;
    assign true_angle        = $signed(nu_out_reg);
    assign converged         = conv_out_reg;
    assign steps_used        = steps_out_reg;

endmodule

// ----- rtl/kepler_anomaly_solver_core.sv -----
// ----------------------------------------------------------------------------
// kepler_anomaly_solver_core
// Newton solver for Kepler's equation with true anomaly output.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes a mean anomaly and eccentricity item;
// output channel (out_valid/out_ready) returns eccentric anomaly, true
// anomaly, a converged flag and the number of newton steps used.
// One item is in work at a time. After the accepting edge the solver evaluates
// the starting guess with a 32-step cordic rotation and residual, then runs
// each newton step as a 66-step restoring divide plus a 32-step cordic
// rotation and residual, then a 32-step square root and a 32-step cordic
// vectoring pass, and finally loads the output slot. All trig goes through one
// shared cordic unit. A new item is taken once the previous result is loaded
// into the output slot.
// The configuration port writes max_iterations (index 0) and tolerance
// (index 1); other indexes are ignored.
// Reset restores max_iterations to 16 and tolerance to 1 and empties the
// output slot. A stalled receiver holds the result in the output slot while
// the next item is already taken and solved; it then waits for the slot.
// ----------------------------------------------------------------------------
module kepler_anomaly_solver_core
    import kas_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        mean_angle,
    input  logic [31:0]        eccentricity,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        eccentric_anomaly,
    output logic signed [31:0] true_angle,
    output logic               converged,
    output logic [5:0]         steps_used,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata
);

    logic [5:0]  max_iter_reg;
    logic [15:0] tol_reg;
    dp_cmd_t     cmd;
    dp_status_t  status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= 6'd16;
            tol_reg      <= 16'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_MAX_ITER)
            begin
                max_iter_reg <= cfg_wdata[5:0];
            end
            else if (cfg_addr == REG_TOLERANCE)
            begin
                tol_reg <= cfg_wdata;
            end
        end
    end

    // sequencer
    kas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // datapath
    kas_dp u_dp (
        .clk               (clk),
        .cmd               (cmd),
        .status            (status),
        .mean_angle        (mean_angle),
        .eccentricity      (eccentricity),
        .max_iterations    (max_iter_reg),
        .tolerance         (tol_reg),
        .eccentric_anomaly (eccentric_anomaly),
        .true_angle        (true_angle),
        .converged         (converged),
        .steps_used        (steps_used)
    );

endmodule

// ----- verif/kepler_anomaly_solver_core_tb.sv -----
// ----------------------------------------------------------------------------
// kepler_anomaly_solver_core_tb
// Drives mean anomaly and eccentricity items into the Newton solver, predicts
// each result with a bit-accurate CORDIC/Newton model and checks all fields.
// ----------------------------------------------------------------------------
module kepler_anomaly_solver_core_tb;
    import kas_pkg::*;

    typedef struct {
        logic [31:0]        ecc_anom;
        logic signed [31:0] true_anom;
        logic               conv;
        logic [5:0]         steps;
    } solution_t;

    // arctangent of 2^-i in 2^-32 turns
    function automatic longint arc_turns(int i);
        logic [31:0] t [0:30];
        t = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
              32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
              32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
              32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
              32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
              32'h00000001};
        if (i > 30) return 0;
        return longint'(t[i]);
    endfunction

    // signed view of a 32-bit turn fraction
    function automatic longint turn_signed(longint a);
        logic [31:0] w;
        w = a[31:0];
        return longint'($signed(w));
    endfunction

    // cordic rotation: cosine and sine in Q30
    function automatic void sin_cos(longint ang, output longint c, output longint s);
        longint z, x, y, dx, dy;
        bit flip;
        z = turn_signed(ang);
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 64'sh40000000) begin z -= 64'sh80000000; flip = 1; end
        else if (z < -64'sh40000000) begin z += 64'sh80000000; flip = 1; end
        for (int i = 0; i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin x -= dx; y += dy; z -= arc_turns(i); end
            else begin x += dx; y -= dy; z += arc_turns(i); end
        end
        if (flip) begin x = -x; y = -y; end
        c = x;
        s = y;
    endfunction

    // cordic vectoring: angle of (x, y) as a turn fraction
    function automatic longint vec_angle(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        if (x < 0) begin x = -x; y = -y; z = 64'h80000000; end
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin x += dx; y -= dy; z += arc_turns(i); end
            else begin x -= dx; y += dy; z -= arc_turns(i); end
        end
        return z & 64'hFFFFFFFF;
    endfunction

    // residual E - M - e sin(E)/2pi and cosine at E
    function automatic void kepler_residual(longint ea, longint ma, longint e,
                                            output longint r, output longint c);
        longint s, t;
        logic signed [127:0] p;
        sin_cos(ea, c, s);
        t = (e * s) >>> 30;
        p = 128'(signed'(t)) * 128'sd683565276;
        r = turn_signed(ea - ma) - longint'(p >>> 32);
    endfunction

    // newton step magnitude, saturated below half a turn
    function automatic longint newton_step(longint num, longint den);
        longint unsigned q, rem, cap;
        cap = 64'h7FFFFFFF;
        q = longint'(num) / den;
        rem = longint'(num) % den;
        if (q > cap) return cap;
        for (int k = 0; k < 32; k++) begin
            q <<= 1;
            rem <<= 1;
            if (rem >= den) begin rem -= den; q |= 1; end
            if (q > cap) return cap;
        end
        return q;
    endfunction

    function automatic longint floor_root(longint unsigned n);
        longint unsigned r, t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    function automatic solution_t solve_kepler(logic [31:0] m_in, logic [31:0] e_in,
                                              logic [5:0] iter_lim, logic [15:0] tol);
        solution_t res;
        longint ma, e, ea, r, cq, c, s, mag, den, q, root, x, y;
        logic signed [127:0] p;
        int steps;
        bit conv;
        ma = m_in;
        e = e_in;
        ea = ma;
        steps = 0;
        conv = 1;
        kepler_residual(ea, ma, e, r, cq);
        forever begin
            mag = r < 0 ? -r : r;
            if (mag <= tol) break;
            if (steps >= iter_lim) begin conv = 0; break; end
            den = (64'sd1 <<< 32) - ((e * cq) >>> 30);
            if (den < 1) den = 1;
            q = newton_step(mag, den);
            ea = (r > 0) ? ((ea - q) & 64'hFFFFFFFF) : ((ea + q) & 64'hFFFFFFFF);
            steps++;
            kepler_residual(ea, ma, e, r, cq);
        end
        sin_cos(ea, c, s);
        root = (e == 0) ? (64'sd1 <<< 32) : floor_root(64'd0 - longint'(e) * e);
        p = 128'(signed'(root)) * 128'(signed'(s));
        y = longint'(p >>> 32);
        x = c - (e >> 2);
        res.ecc_anom = ea[31:0];
        res.true_anom = 32'(vec_angle(x, y));
        res.conv = conv;
        res.steps = steps[5:0];
        return res;
    endfunction

    // scoreboard of pending solutions
    class solution_board;
        solution_t pending[$];
        int errors;
        int checked;
        logic [5:0] iter_lim;
        logic [15:0] tol;

        function void note_item(logic [31:0] m, logic [31:0] e);
            pending.push_back(solve_kepler(m, e, iter_lim, tol));
        endfunction

        function void check_result(solution_t got);
            solution_t exp_s;
            checked++;
            if (pending.size() == 0) begin
                $error("result with no item pending");
                errors++;
                return;
            end
            exp_s = pending.pop_front();
            if (got.ecc_anom !== exp_s.ecc_anom) begin
                $error("eccentric_anomaly exp %h got %h", exp_s.ecc_anom, got.ecc_anom);
                errors++;
            end
            if (got.true_anom !== exp_s.true_anom) begin
                $error("true_angle exp %h got %h", exp_s.true_anom, got.true_anom);
                errors++;
            end
            if (got.conv !== exp_s.conv) begin
                $error("converged exp %b got %b", exp_s.conv, got.conv);
                errors++;
            end
            if (got.steps !== exp_s.steps) begin
                $error("steps_used exp %0d got %0d", exp_s.steps, got.steps);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [31:0] mean_angle, eccentricity, eccentric_anomaly;
    logic signed [31:0] true_angle;
    logic converged;
    logic [5:0] steps_used;
    logic cfg_we;
    logic [1:0] cfg_addr;
    logic [15:0] cfg_wdata;

    solution_board board;
    int stall_mode;

    kepler_anomaly_solver_core dut (.*);

    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial begin
        #60000000;
        $display("tb: failure");
        $finish;
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == REG_MAX_ITER) board.iter_lim = val[5:0];
        else if (idx == REG_TOLERANCE) board.tol = val;
        @(posedge clk);
    endtask

    // valid stays high after acceptance until the next item or a release
    task automatic send_item(logic [31:0] m, logic [31:0] e);
        in_valid <= 1;
        mean_angle <= m;
        eccentricity <= e;
        do @(posedge clk); while (!in_ready);
        board.note_item(m, e);
    endtask

    task automatic release_input;
        in_valid <= 0;
    endtask

    task automatic drain;
        release_input();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // mostly small or moderate eccentricities, some near one
    function automatic logic [31:0] rand_ecc();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 32'h0FFFFFFF);
            1, 2: return $urandom;
            3: return 32'hFFFFFFFF - $urandom_range(0, 32'h00FFFFFF);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic random_phase(int n);
        int burst;
        int gap;
        while (n > 0) begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && n > 0) begin
                send_item($urandom, rand_ecc());
                burst--;
                n--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
            if (gap > 0) begin
                release_input();
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // receiver stall pattern
    always @(posedge clk) begin
        if (stall_mode == 0) out_ready <= 1;
        else if (stall_mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
        else out_ready <= ($urandom_range(0, 9) == 0);
    end

    // output monitor
    always @(posedge clk) begin
        solution_t got;
        if (rst_n && out_valid && out_ready) begin
            got.ecc_anom = eccentric_anomaly;
            got.true_anom = true_angle;
            got.conv = converged;
            got.steps = steps_used;
            board.check_result(got);
        end
    end

    initial begin
        logic [31:0] edge_m [0:5];
        logic [31:0] edge_e [0:4];
        board = new();
        board.iter_lim = 6'd16;
        board.tol = 16'd1;
        stall_mode = 0;
        rst_n = 0;
        in_valid = 0;
        mean_angle = 0;
        eccentricity = 0;
        out_ready = 0;
        cfg_we = 0;
        cfg_addr = 0;
        cfg_wdata = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: angle and eccentricity extremes, half turn, near one
        edge_m = '{32'h0, 32'hFFFFFFFF, 32'h80000000, 32'h40000000, 32'hC0000000, 32'h7FFFFFFF};
        edge_e = '{32'h0, 32'hFFFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFF0000};
        for (int i = 0; i < 6; i++)
            send_item(edge_m[i], edge_e[(i * 3) % 5]);
        send_item(32'h80000000, 32'h0);
        send_item(32'h12345678, 32'hFFFFFFFF);
        send_item(32'h00000001, 32'hF0000000);
        send_item(32'h00000000, 32'hFFFFFFFF);
        drain();

        // zero iteration limit and unused register index
        write_reg(REG_MAX_ITER, 16'd0);
        write_reg(2'd3, 16'hFFFF);
        write_reg(2'd2, 16'h0);
        send_item(32'h0, 32'h0);
        send_item(32'h20000000, 32'h80000000);
        send_item(32'hFFFFFFFF, 32'hFFFFFFFF);
        drain();

        // max limit, zero tolerance
        write_reg(REG_MAX_ITER, 16'd63);
        write_reg(REG_TOLERANCE, 16'd0);
        send_item(32'h55555555, 32'hE0000000);
        send_item(32'hAAAAAAAA, 32'h33333333);
        drain();

        // random phases over several settings
        stall_mode = 1;
        random_phase(100);
        drain();
        write_reg(REG_MAX_ITER, 16'd1);
        write_reg(REG_TOLERANCE, 16'hFFFF);
        stall_mode = 2;
        random_phase(80);
        drain();
        write_reg(REG_MAX_ITER, 16'd5);
        write_reg(REG_TOLERANCE, 16'd40);
        stall_mode = 0;
        random_phase(80);
        drain();
        write_reg(REG_MAX_ITER, 16'd16);
        write_reg(REG_TOLERANCE, 16'd1);
        stall_mode = 1;
        random_phase(120);

        drain();
        $display("covered %0d results over iteration limits 0..63 and tolerances 0..65535",
                 board.checked);
        $display("with sender bursts, receiver stalls and eccentricities near one");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/kas_pkg.sv
rtl/kas_ctrl.sv
rtl/kas_dp.sv
rtl/kepler_anomaly_solver_core.sv
verif/kepler_anomaly_solver_core_tb.sv
